FILE: design/qte_pkg.sv
package qte_pkg;

    localparam int unsigned QW = 32;
    localparam int unsigned TW = 36;             // term width (terms need all 36 bits)
    localparam int unsigned CW = 64;             // cordic x/y width
    localparam int unsigned ZW = 34;             // angle accumulator, q24 degrees
    localparam int unsigned PITCH_W = 25;
    localparam int unsigned ROLL_W = 24;
    localparam int unsigned YAW_W = 25;

    localparam logic signed [ZW-1:0] DEG90 = ZW'(64'sd90 <<< 24);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(64'sd180 <<< 24);
    localparam logic signed [TW-1:0] UNITY = TW'(64'sd1 <<< 30);
    localparam logic signed [31:0] GAIN_Q24 = 32'sd27628053;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                5'd0: r = 34'sd754974720;
                5'd1: r = 34'sd445687602;
                5'd2: r = 34'sd235489088;
                5'd3: r = 34'sd119537938;
                5'd4: r = 34'sd60000934;
                5'd5: r = 34'sd30029717;
                5'd6: r = 34'sd15018523;
                5'd7: r = 34'sd7509720;
                5'd8: r = 34'sd3754917;
                5'd9: r = 34'sd1877466;
                5'd10: r = 34'sd938734;
                5'd11: r = 34'sd469367;
                5'd12: r = 34'sd234684;
                5'd13: r = 34'sd117342;
                5'd14: r = 34'sd58671;
                5'd15: r = 34'sd29335;
                5'd16: r = 34'sd14668;
                5'd17: r = 34'sd7334;
                5'd18: r = 34'sd3667;
                5'd19: r = 34'sd1833;
                5'd20: r = 34'sd917;
                5'd21: r = 34'sd458;
                5'd22: r = 34'sd229;
                5'd23: r = 34'sd115;
                5'd24: r = 34'sd57;
                5'd25: r = 34'sd29;
                5'd26: r = 34'sd14;
                5'd27: r = 34'sd7;
                5'd28: r = 34'sd4;
                5'd29: r = 34'sd2;
                5'd30: r = 34'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [ZW-1:0] clamp_angle(input logic signed [ZW-1:0] v,
                                                          input logic signed [ZW-1:0] lim);
        begin
            if (v > lim)
                return lim;
            else if (v < -lim)
                return -lim;
            return v;
        end
    endfunction

endpackage

FILE: design/qte_if.sv
interface qte_quat_if;
    logic valid;
    logic ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
    logic valid;
    logic ready;
    logic signed [24:0] pitch_angle;
    logic signed [23:0] roll_angle;
    logic signed [24:0] yaw_angle;
    modport source (output valid, pitch_angle, roll_angle, yaw_angle, input ready);
    modport sink (input valid, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

FILE: design/quaternion_to_euler_angles.sv
// Accepts one item per cycle while the output is free; the pipeline advances only then.
// Yaw/roll CORDIC runs first; the pitch CORDIC follows, fed by the yaw magnitude.
// Reset clears only the valid bits; no state carries between items.
module quaternion_to_euler_angles #(
    parameter int unsigned CORDIC_STEPS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    qte_quat_if.sink        quat_in,
    qte_euler_if.source     euler_out
);

    localparam int unsigned CW = qte_pkg::CW;
    localparam int unsigned ZW = qte_pkg::ZW;
    localparam int unsigned TW = qte_pkg::TW;
    localparam int unsigned NS = 2 * CORDIC_STEPS + 6;

    logic adv;
    logic [NS-1:0] vld_reg;

    assign adv = !euler_out.valid || euler_out.ready;
    assign quat_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], quat_in.valid};
    end

    // stage 1: products
    logic signed [63:0] p00_reg, p01_reg, p02_reg, p03_reg, p12_reg, p13_reg;
    logic signed [63:0] p22_reg, p23_reg, p33_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg <= 64'(quat_in.quat_w) * 64'(quat_in.quat_w);
            p01_reg <= 64'(quat_in.quat_w) * 64'(quat_in.quat_x);
            p02_reg <= 64'(quat_in.quat_w) * 64'(quat_in.quat_y);
            p03_reg <= 64'(quat_in.quat_w) * 64'(quat_in.quat_z);
            p12_reg <= 64'(quat_in.quat_x) * 64'(quat_in.quat_y);
            p13_reg <= 64'(quat_in.quat_x) * 64'(quat_in.quat_z);
            p22_reg <= 64'(quat_in.quat_y) * 64'(quat_in.quat_y);
            p23_reg <= 64'(quat_in.quat_y) * 64'(quat_in.quat_z);
            p33_reg <= 64'(quat_in.quat_z) * 64'(quat_in.quat_z);
        end
    end

    // stage 2: terms
    logic signed [TW-1:0] t1_reg, t2_reg, t3_reg, zz_reg, xz_reg;

    function automatic logic signed [TW-1:0] sh(input logic signed [63:0] p);
        logic signed [63:0] s;
        begin
            s = p >>> 29;
            return s[TW-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg <= sh(p12_reg) - sh(p03_reg);
            t2_reg <= sh(p22_reg) + sh(p00_reg) - qte_pkg::UNITY;
            t3_reg <= sh(p23_reg) + sh(p01_reg);
            zz_reg <= sh(p33_reg) + sh(p00_reg) - qte_pkg::UNITY;
            xz_reg <= sh(p13_reg) - sh(p02_reg);
        end
    end

    // stage 3: quadrant pre-rotation for yaw and roll
    logic signed [CW-1:0] ya_x_reg, ya_y_reg, ro_x_reg, ro_y_reg;
    logic signed [ZW-1:0] ya_z_reg, ro_z_reg;

    localparam int unsigned LAG = CORDIC_STEPS + 1;
    logic signed [TW-1:0] t3_line [LAG];
    logic zneg_line [2*CORDIC_STEPS+3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t3_line[0] <= t3_reg;
            for (int i = 1; i < LAG; i++)
                t3_line[i] <= t3_line[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zneg_line[0] <= zz_reg[TW-1];
            for (int i = 1; i < 2 * CORDIC_STEPS + 3; i++)
                zneg_line[i] <= zneg_line[i-1];
        end
    end

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [33:0] z;
        logic zero;
    } prerot_t;

    function automatic prerot_t prerot(input logic signed [63:0] y, input logic signed [63:0] x);
        prerot_t r;
        begin
            r.zero = (x == 0) && (y == 0);
            r.x = x;
            r.y = y;
            r.z = '0;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    r.x = y;
                    r.y = -x;
                    r.z = qte_pkg::DEG90;
                end
                else
                begin
                    r.x = -y;
                    r.y = x;
                    r.z = -qte_pkg::DEG90;
                end
            end
            return r;
        end
    endfunction

    prerot_t ya_pr, ro_pr;
    assign ya_pr = prerot(64'(t1_reg) <<< 24, 64'(t2_reg) <<< 24);
    assign ro_pr = prerot(64'(zz_reg) <<< 24, 64'(xz_reg) <<< 24);

    logic ya_zero_line [CORDIC_STEPS+1];
    logic ro_zero_line [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ya_x_reg <= ya_pr.x;
            ya_y_reg <= ya_pr.y;
            ya_z_reg <= ya_pr.z;
            ro_x_reg <= ro_pr.x;
            ro_y_reg <= ro_pr.y;
            ro_z_reg <= ro_pr.z;
            ya_zero_line[0] <= ya_pr.zero;
            ro_zero_line[0] <= ro_pr.zero;
            for (int i = 1; i < CORDIC_STEPS + 1; i++)
            begin
                ya_zero_line[i] <= ya_zero_line[i-1];
                ro_zero_line[i] <= ro_zero_line[i-1];
            end
        end
    end

    // CORDIC chains for yaw and roll
    logic signed [CW-1:0] yx [CORDIC_STEPS+1];
    logic signed [CW-1:0] yy [CORDIC_STEPS+1];
    logic signed [ZW-1:0] yz [CORDIC_STEPS+1];
    logic signed [CW-1:0] rx [CORDIC_STEPS+1];
    logic signed [CW-1:0] ry [CORDIC_STEPS+1];
    logic signed [ZW-1:0] rz [CORDIC_STEPS+1];

    assign yx[0] = ya_x_reg;
    assign yy[0] = ya_y_reg;
    assign yz[0] = ya_z_reg;
    assign rx[0] = ro_x_reg;
    assign ry[0] = ro_y_reg;
    assign rz[0] = ro_z_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_yr
        qte_cordic_stage #(.SHIFT(g)) u_ya (
            .clk(clk), .en(adv),
            .x_in(yx[g]), .y_in(yy[g]), .z_in(yz[g]),
            .x_out(yx[g+1]), .y_out(yy[g+1]), .z_out(yz[g+1])
        );
        qte_cordic_stage #(.SHIFT(g)) u_ro (
            .clk(clk), .en(adv),
            .x_in(rx[g]), .y_in(ry[g]), .z_in(rz[g]),
            .x_out(rx[g+1]), .y_out(ry[g+1]), .z_out(rz[g+1])
        );
    end

    // finish yaw and roll angles; hand magnitude to the pitch CORDIC
    logic signed [ZW-1:0] yaw_reg, roll_reg;
    logic signed [CW-1:0] mag_reg;
    logic signed [CW-1:0] t3g_reg;
    logic signed [ZW-1:0] roll_c;
    logic signed [ZW-1:0] yaw_line [CORDIC_STEPS+1];
    logic signed [ZW-1:0] roll_line [CORDIC_STEPS+1];

    always_comb
    begin
        roll_c = (ro_zero_line[CORDIC_STEPS] ? '0 :
                  qte_pkg::clamp_angle(rz[CORDIC_STEPS], qte_pkg::DEG180)) - qte_pkg::DEG90;
        if (roll_c >= qte_pkg::DEG90)
            roll_c = qte_pkg::DEG180 - roll_c;
        if (roll_c < -qte_pkg::DEG90)
            roll_c = -qte_pkg::DEG180 - roll_c;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yaw_reg <= ya_zero_line[CORDIC_STEPS] ? '0 :
                       -qte_pkg::clamp_angle(yz[CORDIC_STEPS], qte_pkg::DEG180);
            roll_reg <= roll_c;
            mag_reg <= ya_zero_line[CORDIC_STEPS] ? '0 : yx[CORDIC_STEPS];
            t3g_reg <= 64'(t3_line[LAG-1]) * 64'(qte_pkg::GAIN_Q24);
            yaw_line[0] <= yaw_reg;
            roll_line[0] <= roll_reg;
            for (int i = 1; i < CORDIC_STEPS + 1; i++)
            begin
                yaw_line[i] <= yaw_line[i-1];
                roll_line[i] <= roll_line[i-1];
            end
        end
    end

    // pitch pre-rotation
    prerot_t pi_pr;
    logic signed [CW-1:0] pi_x_reg, pi_y_reg;
    logic signed [ZW-1:0] pi_z_reg;
    logic pi_zero_line [CORDIC_STEPS+1];

    assign pi_pr = prerot(t3g_reg, mag_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pi_x_reg <= pi_pr.x;
            pi_y_reg <= pi_pr.y;
            pi_z_reg <= pi_pr.z;
            pi_zero_line[0] <= pi_pr.zero;
            for (int i = 1; i < CORDIC_STEPS + 1; i++)
                pi_zero_line[i] <= pi_zero_line[i-1];
        end
    end

    logic signed [CW-1:0] px [CORDIC_STEPS+1];
    logic signed [CW-1:0] py [CORDIC_STEPS+1];
    logic signed [ZW-1:0] pz [CORDIC_STEPS+1];

    assign px[0] = pi_x_reg;
    assign py[0] = pi_y_reg;
    assign pz[0] = pi_z_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_pi
        qte_cordic_stage #(.SHIFT(g)) u_pi (
            .clk(clk), .en(adv),
            .x_in(px[g]), .y_in(py[g]), .z_in(pz[g]),
            .x_out(px[g+1]), .y_out(py[g+1]), .z_out(pz[g+1])
        );
    end

    // pitch fold and conversion of all three angles to q16
    logic signed [ZW-1:0] pitch_c;
    logic signed [ZW-1:0] pitch_reg, roll_o_reg, yaw_o_reg;

    always_comb
    begin
        pitch_c = pi_zero_line[CORDIC_STEPS] ? '0 :
                  qte_pkg::clamp_angle(qte_pkg::clamp_angle(pz[CORDIC_STEPS], qte_pkg::DEG180),
                                       qte_pkg::DEG90);
        if (zneg_line[2*CORDIC_STEPS+2])
            pitch_c = (pitch_c >= 0) ? qte_pkg::DEG180 - pitch_c : -qte_pkg::DEG180 - pitch_c;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_reg <= pitch_c;
            roll_o_reg <= roll_line[CORDIC_STEPS];
            yaw_o_reg <= yaw_line[CORDIC_STEPS];
        end
    end

    function automatic logic signed [ZW-1:0] to_q16(input logic signed [ZW-1:0] v);
        logic signed [ZW-1:0] m;
        begin
            if (!v[ZW-1])
                return v >>> 8;
            m = -v;
            m = m >>> 8;
            return -m;
        end
    endfunction

    logic signed [ZW-1:0] pq, rq, yq;
    assign pq = to_q16(pitch_reg);
    assign rq = to_q16(roll_o_reg);
    assign yq = to_q16(yaw_o_reg);

    assign euler_out.valid = vld_reg[NS-1];
    assign euler_out.pitch_angle = pq[qte_pkg::PITCH_W-1:0];
    assign euler_out.roll_angle = rq[qte_pkg::ROLL_W-1:0];
    assign euler_out.yaw_angle = yq[qte_pkg::YAW_W-1:0];

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        euler_out.valid && !euler_out.ready |=> euler_out.valid && $stable(euler_out.yaw_angle))
        else $error("output item changed while stalled");
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_out.valid |-> (rq <= 34'sd5898240) && (rq >= -34'sd5898240))
        else $error("roll out of range");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !euler_out.valid |-> quat_in.ready)
        else $error("input stalled with empty output");
`endif

endmodule

FILE: design/qte_cordic_stage.sv
module qte_cordic_stage #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [qte_pkg::CW-1:0]  x_in,
    input  logic signed [qte_pkg::CW-1:0]  y_in,
    input  logic signed [qte_pkg::ZW-1:0]  z_in,
    output logic signed [qte_pkg::CW-1:0]  x_out,
    output logic signed [qte_pkg::CW-1:0]  y_out,
    output logic signed [qte_pkg::ZW-1:0]  z_out
);

    logic signed [qte_pkg::CW-1:0] x_next;
    logic signed [qte_pkg::CW-1:0] y_next;
    logic signed [qte_pkg::ZW-1:0] z_next;
    logic signed [qte_pkg::CW-1:0] x_reg;
    logic signed [qte_pkg::CW-1:0] y_reg;
    logic signed [qte_pkg::ZW-1:0] z_reg;
    logic signed [qte_pkg::CW-1:0] dx;
    logic signed [qte_pkg::CW-1:0] dy;
    logic signed [qte_pkg::ZW-1:0] a;

    always_comb
    begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        a = qte_pkg::atan_q24(5'(SHIFT));
        if (!y_in[qte_pkg::CW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + a;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

FILE: sim/tb.sv
module tb;

    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } quat_t;

    typedef struct {
        logic signed [qte_pkg::PITCH_W-1:0] pitch;
        logic signed [qte_pkg::ROLL_W-1:0]  roll;
        logic signed [qte_pkg::YAW_W-1:0]   yaw;
    } euler_t;

    typedef struct {
        quat_t  q;
        bit     typed;
        euler_t e;
    } stim_row_t;

    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint A90 = 64'sd90 << 24;
    localparam longint A180 = 64'sd180 << 24;
    localparam longint K_Q24 = 64'sd27628053;
    localparam int LATENCY = 2 * 24 + 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qte_quat_if  quat_in ();
    qte_euler_if euler_out ();

    quaternion_to_euler_angles dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .quat_in   (quat_in.sink),
        .euler_out (euler_out.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50000000;
        $display("FAILURE");
        $finish;
    end

    euler_t    pending_angles[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    stim_row_t rows[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint limit(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // vectoring rotation; returns angle in q24 degrees, gain-scaled length in len
    function automatic longint rotate_to_axis(longint y, longint x, output longint len);
        longint ang, t, dx, dy;
        ang = 0;
        if (x == 0 && y == 0)
        begin
            len = 0;
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; ang = A90;
            end
            else
            begin
                x = -y; y = t; ang = -A90;
            end
        end
        for (int i = 0; i < 24; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; ang += longint'(qte_pkg::atan_q24(i[4:0]));
            end
            else
            begin
                x -= dx; y += dy; ang -= longint'(qte_pkg::atan_q24(i[4:0]));
            end
        end
        len = x;
        return limit(ang, A180);
    endfunction

    function automatic longint deg_q16(longint v);
        return (v >= 0) ? (v >>> 8) : -((-v) >>> 8);
    endfunction

    function automatic euler_t euler_of(quat_t q);
        longint w, x, y, z, p00, p01, p02, p03, p12, p13, p22, p23, p33;
        longint t1, t2, t3, zz, xz, len, dummy, yaw, pitch, roll;
        euler_t e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        p00 = (w * w) >>> 29; p01 = (w * x) >>> 29; p02 = (w * y) >>> 29;
        p03 = (w * z) >>> 29; p12 = (x * y) >>> 29; p13 = (x * z) >>> 29;
        p22 = (y * y) >>> 29; p23 = (y * z) >>> 29; p33 = (z * z) >>> 29;
        t1 = p12 - p03;
        t2 = p22 + p00 - ONE_Q30;
        t3 = p23 + p01;
        zz = p33 + p00 - ONE_Q30;
        xz = p13 - p02;
        yaw = -rotate_to_axis(t1 <<< 24, t2 <<< 24, len);
        pitch = limit(rotate_to_axis(t3 * K_Q24, len, dummy), A90);
        if (zz < 0)
            pitch = (pitch >= 0) ? A180 - pitch : -A180 - pitch;
        roll = rotate_to_axis(zz <<< 24, xz <<< 24, dummy) - A90;
        if (roll >= A90)
            roll = A180 - roll;
        if (roll < -A90)
            roll = -A180 - roll;
        e.pitch = qte_pkg::PITCH_W'(deg_q16(pitch));
        e.roll = qte_pkg::ROLL_W'(deg_q16(roll));
        e.yaw = qte_pkg::YAW_W'(deg_q16(yaw));
        return e;
    endfunction

    function automatic quat_t mk(int w, int x, int y, int z);
        quat_t q;
        q.w = w; q.x = x; q.y = y; q.z = z;
        return q;
    endfunction

    function automatic euler_t ang(int p, int r, int yw);
        euler_t e;
        e.pitch = qte_pkg::PITCH_W'(p); e.roll = qte_pkg::ROLL_W'(r);
        e.yaw = qte_pkg::YAW_W'(yw);
        return e;
    endfunction

    task automatic add_row(quat_t q, bit typed, euler_t e);
        stim_row_t r;
        r.q = q; r.typed = typed; r.e = e;
        rows.push_back(r);
    endtask

    function automatic int rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return int'($urandom_range(0, 2)) - 1;
            default: return int'($urandom_range(0, 32'h80000000)) - 32'sh40000000;
        endcase
    endfunction

    // roughly unit quaternion with random direction
    function automatic quat_t unit_quat();
        quat_t q;
        real a, b, c, d, n;
        a = real'(int'($urandom)); b = real'(int'($urandom));
        c = real'(int'($urandom)); d = real'(int'($urandom));
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0)
            n = 1.0;
        q.w = int'(a / n * 1073741823.0); q.x = int'(b / n * 1073741823.0);
        q.y = int'(c / n * 1073741823.0); q.z = int'(d / n * 1073741823.0);
        return q;
    endfunction

    task automatic send(quat_t q);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            quat_in.valid <= 1'b0;
            @(negedge clk);
        end
        quat_in.valid <= 1'b1;
        quat_in.quat_w <= q.w;
        quat_in.quat_x <= q.x;
        quat_in.quat_y <= q.y;
        quat_in.quat_z <= q.z;
        @(posedge clk);
        while (!quat_in.ready)
            @(posedge clk);
        pending_angles.push_back(euler_of(q));
        @(negedge clk);
    endtask

    // receiver: stall at random, check each item against the oldest expectation
    always @(negedge clk)
        euler_out.ready <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        euler_t e;
        if (rst_n && euler_out.valid && euler_out.ready)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("unexpected item: pitch %0d roll %0d yaw %0d",
                       euler_out.pitch_angle, euler_out.roll_angle, euler_out.yaw_angle);
                errors++;
            end
            else
            begin
                e = pending_angles.pop_front();
                if (euler_out.pitch_angle !== e.pitch)
                begin
                    $error("pitch_angle expected %0d actual %0d", e.pitch, euler_out.pitch_angle);
                    errors++;
                end
                if (euler_out.roll_angle !== e.roll)
                begin
                    $error("roll_angle expected %0d actual %0d", e.roll, euler_out.roll_angle);
                    errors++;
                end
                if (euler_out.yaw_angle !== e.yaw)
                begin
                    $error("yaw_angle expected %0d actual %0d", e.yaw, euler_out.yaw_angle);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        euler_t none;
        int waited;
        none = ang(0, 0, 0);
        quat_in.valid = 1'b0;
        quat_in.quat_w = '0;
        quat_in.quat_x = '0;
        quat_in.quat_y = '0;
        quat_in.quat_z = '0;
        euler_out.ready = 1'b0;

        // identity: level attitude, zz is positive so pitch is not folded
        add_row(mk(32'sh40000000, 0, 0, 0), 1'b0, none);
        add_row(mk(0, 0, 0, 0), 1'b0, none);
        add_row(mk(0, 0, 0, 32'sh40000000), 1'b0, none);
        add_row(mk(0, 32'sh40000000, 0, 0), 1'b0, none);
        add_row(mk(0, 0, 32'sh40000000, 0), 1'b0, none);
        add_row(mk(32'sh2d413ccd, 0, 0, 32'sh2d413ccd), 1'b0, none);
        add_row(mk(32'sh2d413ccd, 32'sh2d413ccd, 0, 0), 1'b0, none);
        add_row(mk(32'sh2d413ccd, 0, 32'sh2d413ccd, 0), 1'b0, none);
        add_row(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff), 1'b0, none);
        add_row(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000), 1'b0, none);
        add_row(mk(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000), 1'b0, none);
        add_row(mk(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff), 1'b0, none);
        add_row(mk(-1, -1, -1, -1), 1'b0, none);
        add_row(mk(1, 1, 1, 1), 1'b0, none);
        add_row(mk(32'sh40000000, 32'sh40000000, 32'sh40000000, 32'sh40000000), 1'b0, none);
        add_row(mk(-32'sh40000000, 0, 0, 0), 1'b0, none);
        add_row(mk(0, -32'sh40000000, 32'sh40000000, 0), 1'b0, none);
        add_row(mk(32'sh16a09e66, 0, 0, 0), 1'b0, none);
        add_row(mk(32'sh5a827999, 0, 0, 0), 1'b0, none);
        add_row(mk(32'sh20000000, 32'sh20000000, -32'sh20000000, 32'sh20000000), 1'b0, none);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 55;
        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                send(rows[i].q);
                pending_angles[$] = rows[i].e;
            end
            else
                send(rows[i].q);
        end

        for (int n = 0; n < 2000; n++)
        begin
            if (n == 667)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 36;
            end
            if (n == 1334)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 3) != 0)
                send(unit_quat());
            else
                send(mk(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
        end
        quat_in.valid <= 1'b0;

        waited = 0;
        while (pending_angles.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending_angles.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: sim.f
design/qte_pkg.sv
design/qte_if.sv
design/qte_cordic_stage.sv
design/quaternion_to_euler_angles.sv
sim/tb.sv
